// ----- src/assert_macros.svh -----
// Assertion helpers used by dcu_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define DCU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dcu property violated");
// Check that a condition never holds outside reset.
`define DCU_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("dcu forbidden condition seen");
`else
`define DCU_ASSERT(lbl, clk, rstn, prop)
`define DCU_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- src/dcu_pkg.sv -----
package dcu_pkg;

  localparam int FIFO_DEPTH_DEF   = 16;
  localparam int CORDIC_ITERS_DEF = 16;

  localparam int PI_Q            = 205887;
  localparam int HALF_PI_Q       = 102944;
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int ATAN_IDX_W      = 5;

  // Register reset values
  localparam logic [23:0] LIN_ACCEL_RST = 24'd65536;
  localparam logic [23:0] ANG_ACCEL_RST = 24'd65536;

  // Register indexes
  localparam logic [1:0] REG_LIN_ACCEL = 2'd0;
  localparam logic [1:0] REG_ANG_ACCEL = 2'd1;
  localparam logic [1:0] REG_LIN_DELAY = 2'd2;
  localparam logic [1:0] REG_ANG_DELAY = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH,
    OP_TIME,
    OP_POP,
    OP_ML,
    OP_MA,
    OP_MP,
    OP_MTH,
    OP_THA,
    OP_CORD,
    OP_X1,
    OP_X2,
    OP_X3,
    OP_Y2,
    OP_Y3,
    OP_WRAP
  } op_e;

  typedef struct packed {
    op_e  op;
    logic latch;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_push;
    logic cordic_last;
    logic wrap_ok;
  } stat_t;

  typedef struct packed {
    logic [23:0] lin_accel;
    logic [23:0] ang_accel;
    logic [23:0] lin_delay;
    logic [23:0] ang_delay;
  } cfg_t;

  // Arctangent of 2^-i in Q30
  function automatic logic signed [33:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/dcu_regs.sv -----
module dcu_regs
  import dcu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lin_accel <= LIN_ACCEL_RST;
      cfg_q.ang_accel <= ANG_ACCEL_RST;
      cfg_q.lin_delay <= '0;
      cfg_q.ang_delay <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_LIN_ACCEL: cfg_q.lin_accel <= pwdata[23:0];
        REG_ANG_ACCEL: cfg_q.ang_accel <= pwdata[23:0];
        REG_LIN_DELAY: cfg_q.lin_delay <= pwdata[23:0];
        REG_ANG_DELAY: cfg_q.ang_delay <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_LIN_ACCEL: prdata = {8'b0, cfg_q.lin_accel};
      REG_ANG_ACCEL: prdata = {8'b0, cfg_q.ang_accel};
      REG_LIN_DELAY: prdata = {8'b0, cfg_q.lin_delay};
      REG_ANG_DELAY: prdata = {8'b0, cfg_q.ang_delay};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- src/dcu_ctrl.sv -----
`include "assert_macros.svh"
module dcu_ctrl
  import dcu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_PUSH, S_TIME, S_POP, S_ML, S_MA, S_MP, S_MTH, S_THA,
    S_CORD, S_X1, S_X2, S_X3, S_Y2, S_Y3, S_WRAP, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Sequence the datapath operations
  always_comb begin
    state_d        = state_q;
    cmd_o.op       = OP_NONE;
    cmd_o.latch    = accept;
    cmd_o.load_out = load;
    case (state_q)
      S_IDLE: if (accept) state_d = S_DISP;
      S_DISP: state_d = stat_i.is_push ? S_PUSH : S_TIME;
      S_PUSH: begin cmd_o.op = OP_PUSH; state_d = S_DONE; end
      S_TIME: begin cmd_o.op = OP_TIME; state_d = S_POP; end
      S_POP:  begin cmd_o.op = OP_POP;  state_d = S_ML; end
      S_ML:   begin cmd_o.op = OP_ML;   state_d = S_MA; end
      S_MA:   begin cmd_o.op = OP_MA;   state_d = S_MP; end
      S_MP:   begin cmd_o.op = OP_MP;   state_d = S_MTH; end
      S_MTH:  begin cmd_o.op = OP_MTH;  state_d = S_THA; end
      S_THA:  begin cmd_o.op = OP_THA;  state_d = S_CORD; end
      S_CORD: begin
        cmd_o.op = OP_CORD;
        if (stat_i.cordic_last) state_d = S_X1;
      end
      S_X1:   begin cmd_o.op = OP_X1; state_d = S_X2; end
      S_X2:   begin cmd_o.op = OP_X2; state_d = S_X3; end
      S_X3:   begin cmd_o.op = OP_X3; state_d = S_Y2; end
      S_Y2:   begin cmd_o.op = OP_Y2; state_d = S_Y3; end
      S_Y3:   begin cmd_o.op = OP_Y3; state_d = S_WRAP; end
      S_WRAP: begin
        cmd_o.op = OP_WRAP;
        if (stat_i.wrap_ok) state_d = S_DONE;
      end
      S_DONE: if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result flag until the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `DCU_ASSERT(a_accept_blocks, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `DCU_ASSERT(a_cordic_runs, clk_i, rst_ni, (state_q == S_CORD && !stat_i.cordic_last) |=> (state_q == S_CORD))
  `DCU_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE))

endmodule

// ----- src/dcu_dp.sv -----
module dcu_dp
  import dcu_pkg::*;
#(
  parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF,
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  cfg_t               cfg_i,
  input  logic               command_i,
  input  logic [15:0]        delta_t_i,
  input  logic signed [23:0] linear_target_i,
  input  logic signed [23:0] angular_target_i,
  output stat_t              stat_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [17:0] heading_out_o,
  output logic signed [23:0] speed_now_o,
  output logic signed [23:0] turn_rate_now_o,
  output logic               overflow_o
);

  localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int ITER_W = $clog2(CORDIC_ITERS);
  localparam logic signed [25:0] HALF_T = 26'(HALF_PI_Q);
  localparam logic signed [25:0] PI_T   = 26'(PI_Q);

  // Latched item
  logic               cmd_q;
  logic [15:0]        dt_q;
  logic signed [23:0] lt_q, at_q;

  // Plant state
  logic [47:0]        elapsed_q;
  logic [31:0]        x_q, y_q;
  logic signed [18:0] heading_q;
  logic signed [23:0] lin_q, lin_goal_q, ang_q, ang_goal_q;
  logic               ovf_q;

  // Target queues: {due, value}
  logic [71:0]        l_mem [FIFO_DEPTH];
  logic [71:0]        a_mem [FIFO_DEPTH];
  logic [71:0]        l_rd_q, a_rd_q;
  logic [PTR_W-1:0]   l_head_q, l_tail_q, a_head_q, a_tail_q;
  logic [CNT_W-1:0]   l_cnt_q, a_cnt_q;
  logic               l_full, a_full, l_due, a_due;
  logic               push_l, push_a;

  // Arithmetic
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p, prod_q, lo_q;
  logic signed [40:0] p_q;
  logic signed [25:0] t_q;
  logic signed [33:0] cx_q, cy_q, z_q, cdx, cdy;
  logic [ITER_W-1:0]  cord_i_q;
  logic signed [19:0] c16, s16;
  logic signed [63:0] comb_sum;
  logic               t_hi, t_lo;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Move speed toward goal by at most step without passing it
  function automatic logic signed [23:0] slew(input logic signed [23:0] now,
                                             input logic signed [23:0] goal,
                                             input logic [23:0] step);
    logic signed [25:0] n, g, s;
    n = {{2{now[23]}}, now};
    g = {{2{goal[23]}}, goal};
    s = {2'b0, step};
    if (g >= n) begin
      n = n + s;
      if (n > g) n = g;
    end else begin
      n = n - s;
      if (n < g) n = g;
    end
    return n[23:0];
  endfunction

  assign l_full = (l_cnt_q == CNT_W'(FIFO_DEPTH));
  assign a_full = (a_cnt_q == CNT_W'(FIFO_DEPTH));
  assign l_due  = (l_cnt_q != '0) && (l_rd_q[71:24] <= elapsed_q);
  assign a_due  = (a_cnt_q != '0) && (a_rd_q[71:24] <= elapsed_q);
  assign push_l = (cmd_i.op == OP_PUSH) && !l_full;
  assign push_a = (cmd_i.op == OP_PUSH) && !a_full;

  assign c16 = cx_q[33:14];
  assign s16 = cy_q[33:14];
  assign cdx = cy_q >>> cord_i_q;
  assign cdy = cx_q >>> cord_i_q;

  assign comb_sum = ({{14{prod_q[49]}}, prod_q} <<< 24) + {{14{lo_q[49]}}, lo_q};
  assign t_hi     = (t_q > HALF_T);
  assign t_lo     = (t_q < -HALF_T);

  assign stat_o.is_push     = cmd_q;
  assign stat_o.cordic_last = (cord_i_q == ITER_W'(CORDIC_ITERS - 1));
  assign stat_o.wrap_ok     = !t_hi && !t_lo;

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_ML:  begin mul_a = {1'b0, cfg_i.lin_accel}; mul_b = {9'b0, dt_q}; end
      OP_MA:  begin mul_a = {1'b0, cfg_i.ang_accel}; mul_b = {9'b0, dt_q}; end
      OP_MP:  begin mul_a = {9'b0, dt_q}; mul_b = {lin_q[23], lin_q}; end
      OP_MTH: begin mul_a = {9'b0, dt_q}; mul_b = {ang_q[23], ang_q}; end
      OP_X1:  begin mul_a = {1'b0, p_q[23:0]}; mul_b = {{5{c16[19]}}, c16}; end
      OP_X2:  begin mul_a = {{8{p_q[40]}}, p_q[40:24]}; mul_b = {{5{c16[19]}}, c16}; end
      OP_X3:  begin mul_a = {1'b0, p_q[23:0]}; mul_b = {{5{s16[19]}}, s16}; end
      OP_Y2:  begin mul_a = {{8{p_q[40]}}, p_q[40:24]}; mul_b = {{5{s16[19]}}, s16}; end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Arithmetic working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (cmd_i.latch) begin
      cmd_q <= command_i;
      dt_q  <= delta_t_i;
      lt_q  <= linear_target_i;
      at_q  <= angular_target_i;
    end
    case (cmd_i.op)
      OP_TIME: begin
        cx_q     <= 34'(CORDIC_GAIN_Q30);
        cy_q     <= '0;
        z_q      <= {heading_q[18], heading_q, 14'b0};
        cord_i_q <= '0;
      end
      OP_MTH: p_q <= prod_q[40:0];
      OP_THA: t_q <= {{7{heading_q[18]}}, heading_q} + {prod_q[40], prod_q[40:16]};
      OP_CORD: begin
        if (!z_q[33]) begin
          cx_q <= cx_q - cdx;
          cy_q <= cy_q + cdy;
          z_q  <= z_q - atan_q30(ATAN_IDX_W'(cord_i_q));
        end else begin
          cx_q <= cx_q + cdx;
          cy_q <= cy_q - cdy;
          z_q  <= z_q + atan_q30(ATAN_IDX_W'(cord_i_q));
        end
        cord_i_q <= cord_i_q + 1'b1;
      end
      OP_X2, OP_Y2: lo_q <= prod_q;
      OP_WRAP: begin
        if (t_hi) t_q <= t_q - PI_T;
        else if (t_lo) t_q <= t_q + PI_T;
      end
      default: ;
    endcase
  end

  // Plant state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      x_q        <= '0;
      y_q        <= '0;
      heading_q  <= '0;
      lin_q      <= '0;
      lin_goal_q <= '0;
      ang_q      <= '0;
      ang_goal_q <= '0;
      ovf_q      <= 1'b0;
      l_head_q   <= '0;
      l_tail_q   <= '0;
      l_cnt_q    <= '0;
      a_head_q   <= '0;
      a_tail_q   <= '0;
      a_cnt_q    <= '0;
    end else begin
      case (cmd_i.op)
        OP_PUSH: begin
          ovf_q <= l_full || a_full;
          if (push_l) begin
            l_tail_q <= ptr_inc(l_tail_q);
            l_cnt_q  <= l_cnt_q + 1'b1;
          end
          if (push_a) begin
            a_tail_q <= ptr_inc(a_tail_q);
            a_cnt_q  <= a_cnt_q + 1'b1;
          end
        end
        OP_TIME: begin
          ovf_q     <= 1'b0;
          elapsed_q <= elapsed_q + {32'b0, dt_q};
        end
        OP_POP: begin
          if (l_due) begin
            lin_goal_q <= l_rd_q[23:0];
            l_head_q   <= ptr_inc(l_head_q);
            l_cnt_q    <= l_cnt_q - 1'b1;
          end
          if (a_due) begin
            ang_goal_q <= a_rd_q[23:0];
            a_head_q   <= ptr_inc(a_head_q);
            a_cnt_q    <= a_cnt_q - 1'b1;
          end
        end
        OP_MA: lin_q <= slew(lin_q, lin_goal_q, prod_q[39:16]);
        OP_MP: ang_q <= slew(ang_q, ang_goal_q, prod_q[39:16]);
        OP_X3: x_q   <= x_q + comb_sum[63:32];
        OP_Y3: y_q   <= y_q + comb_sum[63:32];
        OP_WRAP: if (!t_hi && !t_lo) heading_q <= t_q[18:0];
        default: ;
      endcase
    end
  end

  // Queue storage with registered head read
  always_ff @(posedge clk_i) begin
    if (push_l) l_mem[l_tail_q] <= {elapsed_q + {24'b0, cfg_i.lin_delay}, lt_q};
    if (push_a) a_mem[a_tail_q] <= {elapsed_q + {24'b0, cfg_i.ang_delay}, at_q};
    l_rd_q <= l_mem[l_head_q];
    a_rd_q <= a_mem[a_head_q];
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pos_x_o         <= x_q;
      pos_y_o         <= y_q;
      heading_out_o   <= heading_q[17:0];
      speed_now_o     <= lin_q;
      turn_rate_now_o <= ang_q;
      overflow_o      <= ovf_q;
    end
  end

endmodule

// ----- src/delayed_command_unicycle_model_core.sv -----
// Unicycle plant model with delayed, slew-limited speed commands. An enqueue
// item (command 1) stamps both speed targets with the current time plus each
// axis delay and queues them, FIFO_DEPTH deep per axis; a full queue drops its
// target and sets overflow. An advance item (command 0) adds delta_t to time,
// takes at most one due target per axis, slews both speeds, integrates x and y
// through a CORDIC cosine and sine of the old heading, then integrates and
// wraps heading. Every item returns one result. An advance runs the CORDIC
// iterations and then subtracts or adds pi to the heading until it lies in
// -pi/2..pi/2; the one shared 25x25 multiplier does the slew, position and
// heading products in turn. The block takes the next item once the previous
// result sits in the output register.
module delayed_command_unicycle_model_core
  import dcu_pkg::*;
#(
  parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF,
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [15:0]        delta_t_i,
  input  logic signed [23:0] linear_target_i,
  input  logic signed [23:0] angular_target_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [17:0] heading_out_o,
  output logic signed [23:0] speed_now_o,
  output logic signed [23:0] turn_rate_now_o,
  output logic               overflow_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  dcu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dcu_dp #(
    .FIFO_DEPTH   (FIFO_DEPTH),
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .command_i        (command_i),
    .delta_t_i        (delta_t_i),
    .linear_target_i  (linear_target_i),
    .angular_target_i (angular_target_i),
    .stat_o           (stat),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .heading_out_o    (heading_out_o),
    .speed_now_o      (speed_now_o),
    .turn_rate_now_o  (turn_rate_now_o),
    .overflow_o       (overflow_o)
  );

endmodule

// ----- verif/tb_delayed_command_unicycle_model_core.sv -----
module tb_delayed_command_unicycle_model_core
  import dcu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [17:0] heading;
    logic signed [23:0] speed;
    logic signed [23:0] turn_rate;
    logic               overflow;
  } pose_t;

  // Plant predictor and queue of expected poses
  class pose_scoreboard;
    logic [23:0] lin_accel = LIN_ACCEL_RST;
    logic [23:0] ang_accel = ANG_ACCEL_RST;
    logic [23:0] lin_delay = '0;
    logic [23:0] ang_delay = '0;
    logic [47:0] now_t = '0;
    logic [31:0] x_pos = '0;
    logic [31:0] y_pos = '0;
    longint      theta = 0;
    longint      v_lin = 0, g_lin = 0, v_ang = 0, g_ang = 0;
    logic [47:0] lin_due[$], ang_due[$];
    longint      lin_val[$], ang_val[$];
    pose_t       expected_poses[$];
    int          errors = 0;

    function void set_reg(logic [1:0] idx, logic [23:0] v);
      case (idx)
        REG_LIN_ACCEL: lin_accel = v;
        REG_ANG_ACCEL: ang_accel = v;
        REG_LIN_DELAY: lin_delay = v;
        REG_ANG_DELAY: ang_delay = v;
        default: ;
      endcase
    endfunction

    function longint slew_toward(longint cur, longint goal, logic [23:0] acc,
                                 logic [15:0] dt);
      longint stp;
      stp = longint'({40'd0, acc} * {48'd0, dt}) >>> 16;
      if (goal >= cur) begin
        cur = cur + stp;
        if (cur > goal) cur = goal;
      end else begin
        cur = cur - stp;
        if (cur < goal) cur = goal;
      end
      return cur;
    endfunction

    // Rotate-mode CORDIC, floor shifts, Q16 angle in and 2^-16 out
    function void cos_sin(longint ang, output longint c, output longint s);
      longint cx, cy, z, dx, dy;
      cx = CORDIC_GAIN_Q30;
      cy = 0;
      z = ang * 16384;
      for (int i = 0; i < CORDIC_ITERS_DEF && i < 24; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx; cy += dy; z -= longint'(atan_q30(i[4:0]));
        end else begin
          cx += dx; cy -= dy; z += longint'(atan_q30(i[4:0]));
        end
      end
      c = cx >>> 14;
      s = cy >>> 14;
    endfunction

    function void note_item(logic cmd, logic [15:0] dt, logic signed [23:0] lt,
                            logic signed [23:0] at);
      pose_t  p;
      logic   drop;
      longint c, s, prod, t, k;
      drop = 1'b0;
      if (cmd) begin
        // Push each axis separately; flag when either queue is full
        if (lin_due.size() < FIFO_DEPTH_DEF) begin
          lin_due.push_back(now_t + 48'(lin_delay));
          lin_val.push_back(longint'(lt));
        end else drop = 1'b1;
        if (ang_due.size() < FIFO_DEPTH_DEF) begin
          ang_due.push_back(now_t + 48'(ang_delay));
          ang_val.push_back(longint'(at));
        end else drop = 1'b1;
      end else begin
        now_t = now_t + 48'(dt);
        if (lin_due.size() > 0 && lin_due[0] <= now_t) begin
          g_lin = lin_val.pop_front();
          void'(lin_due.pop_front());
        end
        if (ang_due.size() > 0 && ang_due[0] <= now_t) begin
          g_ang = ang_val.pop_front();
          void'(ang_due.pop_front());
        end
        v_lin = slew_toward(v_lin, g_lin, lin_accel, dt);
        v_ang = slew_toward(v_ang, g_ang, ang_accel, dt);
        cos_sin(theta, c, s);
        prod = longint'(dt) * v_lin;
        x_pos = x_pos + 32'((prod * c) >>> 32);
        y_pos = y_pos + 32'((prod * s) >>> 32);
        t = theta + ((longint'(dt) * v_ang) >>> 16);
        if (t > HALF_PI_Q) begin
          k = (t - HALF_PI_Q + PI_Q - 1) / PI_Q;
          t -= k * PI_Q;
        end
        if (t < -HALF_PI_Q) begin
          k = (-HALF_PI_Q - t + PI_Q - 1) / PI_Q;
          t += k * PI_Q;
        end
        theta = t;
      end
      p.pos_x = x_pos;
      p.pos_y = y_pos;
      p.heading = 18'(theta);
      p.speed = 24'(v_lin);
      p.turn_rate = 24'(v_ang);
      p.overflow = drop;
      expected_poses.push_back(p);
    endfunction

    function void check_pose(pose_t got);
      pose_t e;
      if (expected_poses.size() == 0) begin
        $error("pose result with no item pending");
        errors++;
        return;
      end
      e = expected_poses.pop_front();
      if (got.pos_x !== e.pos_x) begin
        $error("pos_x exp %0d got %0d", e.pos_x, got.pos_x); errors++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("pos_y exp %0d got %0d", e.pos_y, got.pos_y); errors++;
      end
      if (got.heading !== e.heading) begin
        $error("heading_out exp %0d got %0d", e.heading, got.heading); errors++;
      end
      if (got.speed !== e.speed) begin
        $error("speed_now exp %0d got %0d", e.speed, got.speed); errors++;
      end
      if (got.turn_rate !== e.turn_rate) begin
        $error("turn_rate_now exp %0d got %0d", e.turn_rate, got.turn_rate); errors++;
      end
      if (got.overflow !== e.overflow) begin
        $error("overflow exp %0d got %0d", e.overflow, got.overflow); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = 1'b0;
  logic [15:0] delta_t_i = '0;
  logic signed [23:0] linear_target_i = '0;
  logic signed [23:0] angular_target_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o;
  logic signed [17:0] heading_out_o;
  logic signed [23:0] speed_now_o, turn_rate_now_o;
  logic overflow_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pose_scoreboard sb = new();
  bit calm = 1'b0;
  bit stimulus_done = 1'b0;

  delayed_command_unicycle_model_core uut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Write one register over the configuration port
  task automatic write_reg(logic [1:0] idx, logic [23:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {8'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  // Present one item and hold it until accepted; drop valid between items
  task automatic send_item(logic cmd, logic [15:0] dt, logic [23:0] lt, logic [23:0] at);
    int gap;
    gap = 1;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    command_i <= cmd; delta_t_i <= dt;
    linear_target_i <= lt; angular_target_i <= at;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(cmd, dt, lt, at);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_poses.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Mostly moderate steps, some full-range ones
  task automatic random_item();
    logic [23:0] lt, at;
    logic [15:0] dt;
    lt = 24'($urandom());
    at = 24'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      lt = 24'($signed($urandom_range(0, 400000)) - 200000);
      at = 24'($signed($urandom_range(0, 400000)) - 200000);
    end
    dt = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8192));
    send_item($urandom_range(0, 2) == 0, dt, lt, at);
  endtask

  // Receiver with random stall bursts
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_pose('{pos_x_o, pos_y_o, heading_out_o, speed_now_o,
                        turn_rate_now_o, overflow_o});
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(1, 15);
        repeat (stall - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: overflow on a full queue, extremes, large heading steps
    for (int i = 0; i < 17; i++)
      send_item(1'b1, 16'hFFFF, (i == 0) ? 24'h7FFFFF : 24'h800000,
                (i == 1) ? 24'h800000 : 24'h7FFFFF);
    send_item(1'b0, 16'hFFFF, 24'h0, 24'h0);
    send_item(1'b0, 16'h0, 24'hFFFFFF, 24'hFFFFFF);
    send_item(1'b0, 16'hFFFF, 24'h0, 24'h0);
    send_item(1'b0, 16'hFFFF, 24'h0, 24'h0);
    send_item(1'b0, 16'h8000, 24'h0, 24'h0);
    drain();
    // Phases over several register settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_LIN_ACCEL, 24'hFFFFFF); write_reg(REG_ANG_ACCEL, 24'hFFFFFF);
          write_reg(REG_LIN_DELAY, 24'd0); write_reg(REG_ANG_DELAY, 24'd0);
        end
        1: begin
          write_reg(REG_LIN_ACCEL, 24'd0); write_reg(REG_ANG_ACCEL, 24'd0);
          write_reg(REG_LIN_DELAY, 24'hFFFFFF); write_reg(REG_ANG_DELAY, 24'hFFFFFF);
        end
        6: calm = 1'b1;
        default: begin
          write_reg(REG_LIN_ACCEL, 24'($urandom())); write_reg(REG_ANG_ACCEL, 24'($urandom()));
          write_reg(REG_LIN_DELAY, 24'($urandom_range(0, 20000)));
          write_reg(REG_ANG_DELAY, 24'($urandom_range(0, 20000)));
        end
      endcase
      repeat (250) random_item();
      drain();
    end
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    if (sb.errors == 0 && sb.expected_poses.size() == 0)
      $display("delayed_command_unicycle_model_core regression: pass");
    else
      $display("delayed_command_unicycle_model_core regression: fail");
    $finish;
  end

  initial begin
    #(8 * 1000000);
    $display("delayed_command_unicycle_model_core regression: fail");
    $finish;
  end
endmodule
